// ----- sv/poa_pkg.sv -----
// shared types and constants for the page owner allocator
// no dependencies; used by the interfaces and all poa modules
package poa_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PAGE_IDX_W = 10;
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned PAGE_SHIFT = 'hC;

  // value every table entry holds after reset (reset value of free_code)
  localparam logic [OWNER_W-1:0] OWNER_RESET = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLAIM = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2
  } func_e;

  // status of the shared compare unit
  typedef struct packed {
    logic hit;
    logic last;
  } poa_scan_t;

endpackage

// ----- sv/poa_if.sv -----
// valid/ready channel interfaces: request, response and config write
// depends on poa_pkg for field widths
interface poa_req_if;
  logic                              valid;
  logic                              ready;
  logic [poa_pkg::FUNC_W-1:0]        func;
  logic [poa_pkg::PAGE_IDX_W-1:0]    page_index;
  logic [poa_pkg::ADDR_W-1:0]        byte_address;
  logic [poa_pkg::OWNER_W-1:0]       owner_id;

  modport source (output valid, func, page_index, byte_address, owner_id, input ready);
  modport sink   (input valid, func, page_index, byte_address, owner_id, output ready);
endinterface

interface poa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [poa_pkg::ADDR_W-1:0]   page_address;

  modport source (output valid, ok, page_address, input ready);
  modport sink   (input valid, ok, page_address, output ready);
endinterface

interface poa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [poa_pkg::OWNER_W-1:0]   free_code;

  modport source (output valid, free_code, input ready);
  modport sink   (input valid, free_code, output ready);
endinterface

// ----- sv/page_owner_allocator.sv -----
// top level of the page owner allocator: sequencer, config register, result register
// depends on poa_pkg, poa_if, poa_owner_ram and poa_scan_unit
//
// One owner id per page lives in a single-port-write, registered-read RAM of
// PAGE_COUNT entries. After reset a clearing pass writes every entry to zero,
// one entry a cycle, and the request channel stays not ready until it ends;
// config writes are taken during that time. Items are handled one at a time.
// A claim or a free goes through accept, table read, compare and write back,
// and result load; an out of range page or an unused function code goes from
// accept straight to result load. An allocate walks the table from page 0 at
// one entry per cycle, looking at up to PAGE_COUNT entries for a full table;
// the rate is set by the table read port and the one shared compare unit.
// A finished result waits in the output register, and the next item may be
// accepted while it waits. free_code is written through its own channel,
// always ready, and must only change while the block is idle.
module page_owner_allocator #(
  parameter int unsigned PAGE_COUNT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  poa_req_if.sink   in_chan,
  poa_rsp_if.source out_chan,
  poa_cfg_if.sink   cfg_chan
);
  import poa_pkg::*;

  localparam int unsigned IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned CMP_W = ((IDX_W > PAGE_IDX_W) ? IDX_W : PAGE_IDX_W) + 1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // index register doubles as clearing sweep counter and scan pointer
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [OWNER_W-1:0] free_code_q;

  // item payload held while it is worked on
  logic [FUNC_W-1:0]  func_q;
  logic [OWNER_W-1:0] owner_q;

  // pending result
  logic               res_ok_q, res_ok_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_load;

  logic               in_accept;
  logic [PAGE_IDX_W-1:0] req_page;
  logic               req_in_range;

  // table and compare unit hookup
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [OWNER_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [OWNER_W-1:0] entry;
  logic [OWNER_W-1:0] key;
  logic [IDX_W-1:0]   next_idx;
  poa_scan_t          scan;

  assign in_chan.ready  = (state_q == ST_IDLE);
  assign in_accept      = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // a free names its page by byte address, a claim by index
  assign req_page = (in_chan.func == FUNC_FREE)
                    ? in_chan.byte_address[ADDR_W-1:PAGE_SHIFT]
                    : in_chan.page_index;
  assign req_in_range = (CMP_W'(req_page) < CMP_W'(PAGE_COUNT));

  // free looks for the caller's id, claim and allocate look for the free code
  assign key     = (func_q == FUNC_FREE) ? owner_q : free_code_q;
  assign wr_data = (state_q == ST_CLEAR) ? OWNER_RESET
                 : ((func_q == FUNC_FREE) ? free_code_q : owner_q);
  assign wr_addr = idx_q;
  assign wr_en   = (state_q == ST_CLEAR) || ((state_q == ST_CHECK) && scan.hit);

  // in the check state the next entry is fetched ahead, for one entry a cycle
  assign rd_addr = (state_q == ST_CHECK) ? next_idx : idx_q;

  poa_owner_ram #(
    .DEPTH (PAGE_COUNT),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (entry)
  );

  poa_scan_unit #(
    .PAGE_COUNT (PAGE_COUNT),
    .IDX_W      (IDX_W)
  ) u_scan (
    .entry_i  (entry),
    .key_i    (key),
    .idx_i    (idx_q),
    .next_o   (next_idx),
    .status_o (scan)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        idx_d = next_idx;
        if (scan.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          case (in_chan.func)
            FUNC_ALLOC: begin
              idx_d   = '0;
              state_d = ST_READ;
            end
            FUNC_CLAIM, FUNC_FREE: begin
              idx_d   = IDX_W'(req_page);
              state_d = req_in_range ? ST_READ : ST_FINISH;
            end
            default: begin
              // unused function code: no table access
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (scan.hit) begin
          res_ok_d = 1'b1;
          if (func_q == FUNC_ALLOC) begin
            res_addr_d = {PAGE_IDX_W'(idx_q), {PAGE_SHIFT{1'b0}}};
          end
          state_d = ST_FINISH;
        end else if ((func_q == FUNC_ALLOC) && !scan.last) begin
          idx_d = next_idx;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_chan.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      free_code_q <= OWNER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_chan.valid && cfg_chan.ready) begin
        free_code_q <= cfg_chan.free_code;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    if (in_accept) begin
      func_q  <= in_chan.func;
      owner_q <= in_chan.owner_id;
    end
    if (out_load) begin
      out_ok_q   <= res_ok_q;
      out_addr_q <= res_addr_q;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.ok           = out_ok_q;
  assign out_chan.page_address = out_addr_q;

`ifndef ASSERT_OFF
  // an accepted item always moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after an accepted item");

  // only an allocate keeps walking the table
  a_single_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CHECK) && (func_q != FUNC_ALLOC)) |=> (state_q == ST_FINISH))
    else $error("claim or free looked at more than one entry");

  // an address is only returned with a successful result
  a_addr_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && (out_chan.page_address != '0)) |-> out_chan.ok)
    else $error("page address returned without ok");

  // a table write outside the clearing pass is always a matched entry
  a_write_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (state_q != ST_CLEAR)) |-> ((state_q == ST_CHECK) && scan.hit))
    else $error("owner table written without a match");
`endif

endmodule

// ----- sv/poa_owner_ram.sv -----
// owner table storage: one write port, one registered read port
// depends on poa_pkg for the entry width
module poa_owner_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [poa_pkg::OWNER_W-1:0] wr_data_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [poa_pkg::OWNER_W-1:0] rd_data_o
);
  import poa_pkg::*;

  logic [OWNER_W-1:0] mem_q [DEPTH];
  logic [OWNER_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/poa_scan_unit.sv -----
// shared compare and step unit: entry match, next index, last page flag
// depends on poa_pkg for poa_scan_t
module poa_scan_unit #(
  parameter int unsigned PAGE_COUNT = 1024,
  parameter int unsigned IDX_W      = 10
) (
  input  logic [poa_pkg::OWNER_W-1:0] entry_i,
  input  logic [poa_pkg::OWNER_W-1:0] key_i,
  input  logic [IDX_W-1:0]            idx_i,
  output logic [IDX_W-1:0]            next_o,
  output poa_pkg::poa_scan_t          status_o
);
  import poa_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);

  assign status_o.hit  = (entry_i == key_i);
  assign status_o.last = (idx_i == LAST_IDX);
  assign next_o        = idx_i + IDX_W'(1);

endmodule

// ----- tb/tb.sv -----
// self-checking bench for page_owner_allocator: directed and random claim, allocate and free items
// depends on poa_pkg, the poa_if interfaces and the page_owner_allocator rtl
module tb;
  import poa_pkg::*;

  localparam int unsigned PAGE_COUNT = 1024;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused function code

  // two copies of the owner table: one that plans stimulus, one that checks
  localparam int GEN_VIEW = 0;
  localparam int CHK_VIEW = 1;

  // last phase receiver hold-off, long enough to back up the request side
  localparam int unsigned HOLD_CYCLES = 400;
  // drain margin at the end: one full table walk plus the pipeline
  localparam int unsigned DRAIN_CYCLES = PAGE_COUNT + 16;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [ADDR_W-1:0]     byte_address;
    logic [OWNER_W-1:0]    owner_id;
  } page_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] page_address;
  } page_rsp_t;

  logic clk_i;
  logic rst_ni;

  poa_req_if req_bus();
  poa_rsp_if rsp_bus();
  poa_cfg_if cfg_bus();

  page_owner_allocator #(
    .PAGE_COUNT(PAGE_COUNT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (req_bus),
    .out_chan(rsp_bus),
    .cfg_chan(cfg_bus)
  );

  // owner table and free code, per view
  logic [OWNER_W-1:0] owners [0:1][0:PAGE_COUNT-1];
  logic [OWNER_W-1:0] free_code [0:1];

  page_req_t req_backlog[$];   // items waiting for the driver
  page_rsp_t due_replies[$];   // replies owed by the block, oldest first
  int unsigned held_pages[$];  // pages the planner believes are owned

  int unsigned n_sent;
  int unsigned n_done;
  int unsigned n_err;
  int unsigned send_idle;      // percent of cycles the sender holds back
  int unsigned recv_stall;     // percent of cycles the receiver stalls
  bit          req_took;
  bit          hold_arm;
  bit          hold_done;
  int unsigned hold_left;

  // 20 time unit clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop, several times the slowest legal run (every item a full table walk)
  initial begin
    #(64_000_000);
    $display("tb: errors");
    $finish;
  end

  // one claim, allocate or free applied to one view of the table
  function automatic page_rsp_t apply_page_op(input int v, input page_req_t r);
    page_rsp_t   res;
    int unsigned i;
    int unsigned pg;
    logic [31:0] addr;
    res = '0;
    case (r.func)
      FUNC_CLAIM: begin
        // range check first, then the free test
        if (r.page_index < PAGE_COUNT && owners[v][r.page_index] == free_code[v]) begin
          owners[v][r.page_index] = r.owner_id;
          res.ok = 1'b1;
        end
      end
      FUNC_ALLOC: begin
        // first fit from page 0
        for (i = 0; i < PAGE_COUNT; i++) begin
          if (!res.ok && owners[v][i] == free_code[v]) begin
            owners[v][i] = r.owner_id;
            res.ok = 1'b1;
            addr = i << PAGE_SHIFT;
            res.page_address = addr[ADDR_W-1:0];
          end
        end
      end
      FUNC_FREE: begin
        // only the owner may release; the page gets the current free code
        pg = 32'(r.byte_address >> PAGE_SHIFT);
        if (pg < PAGE_COUNT && owners[v][pg] == r.owner_id) begin
          owners[v][pg] = free_code[v];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void flag_fault(input string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endfunction

  // mostly random owners, now and then one equal to the free code
  function automatic logic [OWNER_W-1:0] pick_owner();
    if ($urandom_range(0, 15) == 0) return free_code[GEN_VIEW];
    return OWNER_W'($urandom_range(0, 65535));
  endfunction

  // random byte address over the full field
  function automatic logic [ADDR_W-1:0] any_addr();
    return ADDR_W'($urandom_range(0, 4194303));
  endfunction

  // plan one item against the generator view and hand it to the driver
  task automatic queue_op(input logic [FUNC_W-1:0] f, input int unsigned pg,
                          input logic [ADDR_W-1:0] addr, input logic [OWNER_W-1:0] own);
    page_req_t r;
    page_rsp_t res;
    r.func         = f;
    r.page_index   = pg[PAGE_IDX_W-1:0];
    r.byte_address = addr;
    r.owner_id     = own;
    res = apply_page_op(GEN_VIEW, r);
    if (res.ok && f == FUNC_CLAIM) held_pages.push_back(32'(r.page_index));
    if (res.ok && f == FUNC_ALLOC) held_pages.push_back(32'(res.page_address >> PAGE_SHIFT));
    req_backlog.push_back(r);
    n_sent++;
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(input int unsigned pg);
    logic [31:0] a;
    a = (pg << PAGE_SHIFT) | $urandom_range(0, 4095);
    return a[ADDR_W-1:0];
  endfunction

  // free code write, only while nothing is in flight
  task automatic write_free_code(input logic [OWNER_W-1:0] code);
    @(negedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.free_code <= code;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    free_code[GEN_VIEW] = code;
  endtask

  // one random item, biased toward owned pages so frees and claims land
  task automatic queue_random_op();
    int unsigned pick;
    int unsigned pg;
    int unsigned idx;
    int unsigned tries;
    pick = $urandom_range(0, 99);
    pg   = $urandom_range(0, PAGE_COUNT - 1);
    if (pick < 30) begin
      queue_op(FUNC_ALLOC, pg, any_addr(), pick_owner());
    end else if (pick < 55 && held_pages.size() != 0) begin
      // well formed free: a held page and its true owner
      idx = $urandom_range(0, held_pages.size() - 1);
      pg  = held_pages[idx];
      held_pages.delete(idx);
      queue_op(FUNC_FREE, $urandom_range(0, PAGE_COUNT - 1), page_addr(pg),
               owners[GEN_VIEW][pg]);
    end else if (pick < 70) begin
      // claim, looking a little for a free page
      tries = 0;
      while (tries < 8 && owners[GEN_VIEW][pg] != free_code[GEN_VIEW]) begin
        pg = $urandom_range(0, PAGE_COUNT - 1);
        tries++;
      end
      queue_op(FUNC_CLAIM, pg, any_addr(), pick_owner());
    end else if (pick < 80 && held_pages.size() != 0) begin
      // claim of a page someone holds
      pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
      queue_op(FUNC_CLAIM, pg, any_addr(), pick_owner());
    end else if (pick < 90 && held_pages.size() != 0) begin
      // free by a caller that most likely is not the owner
      pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
      queue_op(FUNC_FREE, $urandom_range(0, PAGE_COUNT - 1), page_addr(pg), pick_owner());
    end else if (pick < 96) begin
      queue_op(FUNC_FREE, pg, any_addr(), pick_owner());
    end else begin
      queue_op(FUNC_SPARE, pg, any_addr(), OWNER_W'($urandom_range(0, 65535)));
    end
  endtask

  // drain, set the free code and idling, queue an allocate and a batch of random items,
  // then arm the hold-off if asked; the first allocate after a code change usually sees a full table
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [OWNER_W-1:0] code, input int unsigned count,
                           input bit squeeze);
    int unsigned k;
    wait (n_done >= n_sent);
    write_free_code(code);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    queue_op(FUNC_ALLOC, 0, '0, pick_owner());
    for (k = 0; k < count; k++) queue_random_op();
    if (squeeze) hold_arm = 1'b1;
  endtask

  // request driver: a new item goes out at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    page_req_t nxt;
    if (rst_ni && (!req_bus.valid || req_took)) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        nxt = req_backlog.pop_front();
        req_bus.valid        <= 1'b1;
        req_bus.func         <= nxt.func;
        req_bus.page_index   <= nxt.page_index;
        req_bus.byte_address <= nxt.byte_address;
        req_bus.owner_id     <= nxt.owner_id;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // reply side ready: random stalls, plus one long hold-off when armed
  always @(negedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // monitor: replies are checked before the item accepted at the same edge is predicted
  always @(posedge clk_i) begin
    page_rsp_t want;
    page_req_t got;
    req_took <= rst_ni && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
    if (rst_ni) begin
      if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)
        free_code[CHK_VIEW] = cfg_bus.free_code;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        n_done++;
        if (due_replies.size() == 0) begin
          flag_fault($sformatf("unexpected reply ok=%0b page_address=%h",
                               rsp_bus.ok, rsp_bus.page_address));
        end else begin
          want = due_replies.pop_front();
          if (rsp_bus.ok !== want.ok || rsp_bus.page_address !== want.page_address)
            flag_fault($sformatf({"reply %0d: expected ok=%0b page_address=%h, ",
                                  "got ok=%0b page_address=%h"},
                                 n_done, want.ok, want.page_address,
                                 rsp_bus.ok, rsp_bus.page_address));
        end
      end
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
        got.func         = req_bus.func;
        got.page_index   = req_bus.page_index;
        got.byte_address = req_bus.byte_address;
        got.owner_id     = req_bus.owner_id;
        due_replies.push_back(apply_page_op(CHK_VIEW, got));
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned i;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.func         = FUNC_CLAIM;
    req_bus.page_index   = '0;
    req_bus.byte_address = '0;
    req_bus.owner_id     = '0;
    rsp_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.free_code    = '0;
    n_sent     = 0;
    n_done     = 0;
    n_err      = 0;
    send_idle  = 0;
    recv_stall = 0;
    req_took   = 1'b0;
    hold_arm   = 1'b0;
    hold_done  = 1'b0;
    hold_left  = 0;
    for (i = 0; i < PAGE_COUNT; i++) begin
      owners[GEN_VIEW][i] = OWNER_RESET;
      owners[CHK_VIEW][i] = OWNER_RESET;
    end
    free_code[GEN_VIEW] = OWNER_RESET;
    free_code[CHK_VIEW] = OWNER_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the write lands during the clearing pass, the driver just waits for ready
    write_free_code(16'h0000);

    // directed: first fit, taken pages, wrong owner, owner equal to the free code,
    // unused function code, address and owner extremes
    queue_op(FUNC_ALLOC, 0, 22'h3FFFFF, 16'hFFFF);
    queue_op(FUNC_ALLOC, 1023, 22'h000000, 16'h0001);
    queue_op(FUNC_CLAIM, 1023, 22'h000000, 16'hFFFF);
    queue_op(FUNC_CLAIM, 1023, 22'h3FFFFF, 16'h0002);
    queue_op(FUNC_CLAIM, 0, 22'h000000, 16'h0005);
    queue_op(FUNC_FREE, 0, 22'h3FFFFF, 16'h0003);
    queue_op(FUNC_FREE, 1023, 22'h3FFFFF, 16'hFFFF);
    queue_op(FUNC_CLAIM, 1023, 22'h000000, 16'h0000);
    queue_op(FUNC_ALLOC, 0, 22'h000000, 16'h0000);
    queue_op(FUNC_FREE, 0, 22'h002ABC, 16'h0000);
    queue_op(FUNC_FREE, 0, 22'h000FFF, 16'hFFFF);
    queue_op(FUNC_SPARE, 1023, 22'h3FFFFF, 16'hFFFF);
    queue_op(FUNC_SPARE, 0, 22'h000000, 16'h0000);
    queue_op(FUNC_CLAIM, 0, 22'h155555, 16'h5A5A);
    queue_op(FUNC_FREE, 682, 22'h001000, 16'h0001);
    queue_op(FUNC_FREE, 0, 22'h000000, 16'h5A5A);

    run_phase(0, 0, 16'h0000, 112, 1'b0);
    run_phase(62, 0, OWNER_W'($urandom_range(1, 65534)), 112, 1'b0);
    run_phase(0, 62, 16'hFFFF, 112, 1'b0);
    run_phase(17, 17, OWNER_W'($urandom_range(0, 65535)), 112, 1'b0);
    // sender never idles while the receiver holds off
    run_phase(0, 0, 16'h0000, 112, 1'b1);

    wait (n_done >= n_sent);
    recv_stall = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_replies.size() != 0) begin
      flag_fault($sformatf("%0d replies never arrived", due_replies.size()));
    end
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
